[hw/rtl/prpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpi_pkg
// Shared types, codes and fixed formats of the PageRank power-iteration block.
// ----------------------------------------------------------------------------
package prpi_pkg;

  // field and datapath widths
  localparam int VID_W     = 10;              // vertex id
  localparam int RANK_W    = 33;              // Q1.32 rank
  localparam int FRAC_W    = 32;              // rank fraction bits
  localparam int ACC_W     = 62;              // saturating accumulators
  localparam int ALPHA_W   = 16;              // Q0.16 damping
  localparam int ITER_W    = 16;
  localparam int VCNT_W    = 11;
  localparam int CONV_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = RANK_W + FRAC_W; // divider numerator / quotient
  localparam int DIV_CNT_W = 7;

  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [DIV_W-1:0]  div_t;

  localparam acc_t  ACC_MAX  = {ACC_W{1'b1}};
  localparam rank_t RANK_MAX = {RANK_W{1'b1}};
  localparam acc_t  RANK_ONE = acc_t'(1) << FRAC_W;

  // request commands
  typedef enum logic [1:0] {
    CMD_ADD_EDGE   = 2'd0,
    CMD_WRITE_RANK = 2'd1,
    CMD_RUN        = 2'd2,
    CMD_READ_RANK  = 2'd3
  } cmd_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_VERTEX = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT   = 2'd3;

  // configuration reset values
  localparam logic [VCNT_W-1:0]  VCOUNT_RST = 11'd1024;
  localparam logic [ALPHA_W-1:0] DAMP_RST   = 16'd55705;
  localparam logic [CONV_W-1:0]  CONV_RST   = 32'd4295;
  localparam logic [ITER_W-1:0]  ILIM_RST   = 16'd100;

  // sequencer states
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CMD, S_EDGE_WR, S_READ, S_DONE,
    S_RUN_INIT, S_CHECK, S_SUM_RD, S_SUM_ACC,
    S_NORM_RD, S_NORM_LD, S_NORM_DIV, S_NORM_FIN,
    S_DEG_LD, S_DEG_DIV, S_DEG_FIN, S_NORM_WR,
    S_SHARE_MUL, S_SD_LD, S_SD_DIV, S_SD_FIN, S_ST_DIV, S_ST_FIN,
    S_FLOW_RD, S_FLOW_SRC, S_FLOW_ADD,
    S_UPD_RD, S_UPD_MUL, S_UPD_WR, S_ITER_END
  } state_t;

endpackage

[hw/rtl/prpi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpi_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pagerank_power_iteration.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_power_iteration
// PageRank power iteration with dangling-vertex mass over a loaded edge list.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. in_cmd selects
// add edge, write rank, run, or read rank. Every request gives one result,
// shown for one cycle with out_valid; the receiver cannot stall it, so the
// result must be sampled in that cycle. iterations_run and final_difference
// always report the last run. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// A run takes per iteration a sum pass, a normalization pass (serial
// divider, used for the rank divide and the out-degree divide), the shares,
// an inflow pass over the edges (read-modify-write on the inflow memory) and
// an update pass.
// Reset: a clearing pass zeroes all MAX_VERTICES out-degree entries; busy
// stays high until it ends. Config registers return to their defaults.
// ----------------------------------------------------------------------------
module pagerank_power_iteration #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 8192
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_cmd,
  input  logic [prpi_pkg::VID_W-1:0]           in_source_vertex,
  input  logic [prpi_pkg::VID_W-1:0]           in_target_vertex,
  input  logic [prpi_pkg::RANK_W-1:0]          in_rank_in,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [prpi_pkg::RANK_W-1:0]          out_rank_out,
  output logic [prpi_pkg::ITER_W-1:0]          out_iterations_run,
  output logic [prpi_pkg::RANK_W-1:0]          out_final_difference,
  input  logic                                 cfg_we,
  input  logic [prpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prpi_pkg::CFG_W-1:0]           cfg_data
);

  localparam int VA     = $clog2(MAX_VERTICES);
  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int ETW    = $clog2(MAX_EDGES + 1);
  localparam int EA     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW     = (NW > prpi_pkg::VID_W) ? NW : prpi_pkg::VID_W;
  localparam int EDGE_W = 2 * prpi_pkg::VID_W;
  localparam int DW     = ETW;
  localparam int AW     = prpi_pkg::ACC_W;

  prpi_pkg::state_t state_r, state_nxt;

  // configuration
  logic [prpi_pkg::VCNT_W-1:0]  vcount_r;
  logic [prpi_pkg::ALPHA_W-1:0] damp_r;
  logic [prpi_pkg::CONV_W-1:0]  conv_r;
  logic [prpi_pkg::ITER_W-1:0]  ilim_r;

  // latched request and result
  prpi_pkg::cmd_t              cmd_r;
  logic [prpi_pkg::VID_W-1:0]  src_r, dst_r;
  prpi_pkg::rank_t             rin_r;
  prpi_pkg::status_t           status_r;
  prpi_pkg::rank_t             rout_r;

  // persistent state
  logic [ETW-1:0]              edge_total_r;
  logic [prpi_pkg::ITER_W-1:0] iter_r;
  prpi_pkg::rank_t             last_r;

  // run datapath
  logic [NW-1:0]   k_r;
  logic [ETW-1:0]  e_r;
  prpi_pkg::acc_t  total_r, dang_r, diff_r, sd_r;
  prpi_pkg::rank_t prev_r, contrib_r, st_r, old_r;
  logic [DW-1:0]   deg_r;
  prpi_pkg::acc_t  phi_r;
  logic [31:0]     plo_r;
  logic [prpi_pkg::VID_W-1:0] fdst_r;

  // serial divider
  prpi_pkg::div_t              div_num_r, div_quo_r;
  prpi_pkg::acc_t              div_den_r, div_rem_r;
  logic [prpi_pkg::DIV_CNT_W-1:0] div_cnt_r;

  // memory ports
  logic                        rank_we, prev_we, cont_we, infl_we, deg_we, edge_we;
  logic [VA-1:0]               rank_wa, rank_ra, k_addr, cont_ra, infl_wa, infl_ra;
  logic [VA-1:0]               deg_wa, deg_ra;
  prpi_pkg::rank_t             rank_wd, rank_rd, prev_rd, cont_rd;
  prpi_pkg::acc_t              infl_wd, infl_rd;
  logic [DW-1:0]               deg_wd, deg_rd;
  logic [EA-1:0]               edge_wa, edge_ra;
  logic [EDGE_W-1:0]           edge_wd, edge_rd;

  // ---------------- decode helpers ----------------
  logic [NW-1:0] n;
  logic          src_bad, dst_bad, store_full, k_last, e_last, in_div;
  logic [prpi_pkg::VID_W-1:0] fsrc, fdst;
  logic          flow_skip;

  // effective vertex count
  always_comb begin
    if (32'(vcount_r) > MAX_VERTICES) begin
      n = NW'(MAX_VERTICES);
    end else if (vcount_r == '0) begin
      n = NW'(1);
    end else begin
      n = NW'(vcount_r);
    end
  end

  assign src_bad    = CW'(src_r) >= CW'(n);
  assign dst_bad    = CW'(dst_r) >= CW'(n);
  assign store_full = edge_total_r == ETW'(MAX_EDGES);
  assign k_last     = (k_r + NW'(1)) == n;
  assign e_last     = (e_r + ETW'(1)) == edge_total_r;
  assign k_addr     = k_r[VA-1:0];
  assign fsrc       = edge_rd[EDGE_W-1:prpi_pkg::VID_W];
  assign fdst       = edge_rd[prpi_pkg::VID_W-1:0];
  assign flow_skip  = (CW'(fsrc) >= CW'(n)) || (CW'(fdst) >= CW'(n));
  assign in_div     = (state_r == prpi_pkg::S_NORM_DIV) || (state_r == prpi_pkg::S_DEG_DIV) ||
                      (state_r == prpi_pkg::S_SD_DIV)   || (state_r == prpi_pkg::S_ST_DIV);

  // ---------------- arithmetic ----------------
  logic [AW:0]     div_sh, div_diff;
  logic            div_ge;
  prpi_pkg::rank_t norm_q;
  prpi_pkg::acc_t  mul_x, phi_nxt, m_sum;
  logic [31:0]     plo_nxt;
  logic [AW+1:0]   upd_sum;
  prpi_pkg::rank_t upd_v, upd_delta;
  logic [AW:0]     diff_sum, total_sum, dang_sum, flow_sum;
  prpi_pkg::acc_t  diff_sat, total_sat, dang_sat, flow_sat;
  logic [16:0]     tele_w;

  // one restoring-division step per cycle
  assign div_sh   = {div_rem_r, div_num_r[prpi_pkg::DIV_W-1]};
  assign div_diff = div_sh - {1'b0, div_den_r};
  assign div_ge   = div_sh >= {1'b0, div_den_r};
  assign norm_q   = (div_quo_r > prpi_pkg::DIV_W'(prpi_pkg::RANK_MAX)) ?
                    prpi_pkg::RANK_MAX : div_quo_r[prpi_pkg::RANK_W-1:0];

  // x * alpha / 2^16 as two partial products
  assign mul_x   = (state_r == prpi_pkg::S_UPD_MUL) ? infl_rd : dang_r;
  assign phi_nxt = mul_x[AW-1:16] * damp_r;
  assign plo_nxt = mul_x[15:0] * damp_r;
  assign m_sum   = phi_r + AW'(plo_r[31:16]);

  // rank update with saturation to Q1.32
  assign upd_sum   = (AW+2)'(m_sum) + (AW+2)'(sd_r) + (AW+2)'(st_r);
  assign upd_v     = (upd_sum > (AW+2)'(prpi_pkg::RANK_MAX)) ?
                     prpi_pkg::RANK_MAX : upd_sum[prpi_pkg::RANK_W-1:0];
  assign upd_delta = (upd_v >= old_r) ? (upd_v - old_r) : (old_r - upd_v);

  // saturating accumulators
  assign diff_sum  = {1'b0, diff_r} + (AW+1)'(upd_delta);
  assign diff_sat  = (diff_sum > {1'b0, prpi_pkg::ACC_MAX}) ? prpi_pkg::ACC_MAX : diff_sum[AW-1:0];
  assign total_sum = {1'b0, total_r} + (AW+1)'(rank_rd);
  assign total_sat = (total_sum > {1'b0, prpi_pkg::ACC_MAX}) ? prpi_pkg::ACC_MAX : total_sum[AW-1:0];
  assign dang_sum  = {1'b0, dang_r} + (AW+1)'(rank_rd);
  assign dang_sat  = (dang_sum > {1'b0, prpi_pkg::ACC_MAX}) ? prpi_pkg::ACC_MAX : dang_sum[AW-1:0];
  assign flow_sum  = {1'b0, infl_rd} + (AW+1)'(cont_rd);
  assign flow_sat  = (flow_sum > {1'b0, prpi_pkg::ACC_MAX}) ? prpi_pkg::ACC_MAX : flow_sum[AW-1:0];
  assign tele_w    = 17'h10000 - {1'b0, damp_r};

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prpi_pkg::S_CLEAR:
        if (k_r == NW'(MAX_VERTICES - 1)) state_nxt = prpi_pkg::S_IDLE;
      prpi_pkg::S_IDLE:
        if (start) state_nxt = prpi_pkg::S_CMD;
      prpi_pkg::S_CMD: begin
        case (cmd_r)
          prpi_pkg::CMD_ADD_EDGE:
            state_nxt = (src_bad || dst_bad || store_full) ? prpi_pkg::S_DONE : prpi_pkg::S_EDGE_WR;
          prpi_pkg::CMD_WRITE_RANK: state_nxt = prpi_pkg::S_DONE;
          prpi_pkg::CMD_RUN:        state_nxt = prpi_pkg::S_RUN_INIT;
          default:                  state_nxt = dst_bad ? prpi_pkg::S_DONE : prpi_pkg::S_READ;
        endcase
      end
      prpi_pkg::S_EDGE_WR:  state_nxt = prpi_pkg::S_DONE;
      prpi_pkg::S_READ:     state_nxt = prpi_pkg::S_DONE;
      prpi_pkg::S_DONE:     state_nxt = prpi_pkg::S_IDLE;
      prpi_pkg::S_RUN_INIT: state_nxt = prpi_pkg::S_CHECK;
      prpi_pkg::S_CHECK:
        state_nxt = ((diff_r > AW'(conv_r)) && (iter_r < ilim_r)) ?
                    prpi_pkg::S_SUM_RD : prpi_pkg::S_DONE;
      prpi_pkg::S_SUM_RD:   state_nxt = prpi_pkg::S_SUM_ACC;
      prpi_pkg::S_SUM_ACC:  state_nxt = k_last ? prpi_pkg::S_NORM_RD : prpi_pkg::S_SUM_RD;
      prpi_pkg::S_NORM_RD:  state_nxt = prpi_pkg::S_NORM_LD;
      prpi_pkg::S_NORM_LD:
        state_nxt = ((iter_r == '0) || (total_r == '0)) ? prpi_pkg::S_DEG_LD : prpi_pkg::S_NORM_DIV;
      prpi_pkg::S_NORM_DIV: if (div_cnt_r == '0) state_nxt = prpi_pkg::S_NORM_FIN;
      prpi_pkg::S_NORM_FIN: state_nxt = prpi_pkg::S_DEG_LD;
      prpi_pkg::S_DEG_LD:
        state_nxt = (deg_r == '0) ? prpi_pkg::S_NORM_WR : prpi_pkg::S_DEG_DIV;
      prpi_pkg::S_DEG_DIV:  if (div_cnt_r == '0) state_nxt = prpi_pkg::S_DEG_FIN;
      prpi_pkg::S_DEG_FIN:  state_nxt = prpi_pkg::S_NORM_WR;
      prpi_pkg::S_NORM_WR:  state_nxt = k_last ? prpi_pkg::S_SHARE_MUL : prpi_pkg::S_NORM_RD;
      prpi_pkg::S_SHARE_MUL: state_nxt = prpi_pkg::S_SD_LD;
      prpi_pkg::S_SD_LD:    state_nxt = prpi_pkg::S_SD_DIV;
      prpi_pkg::S_SD_DIV:   if (div_cnt_r == '0) state_nxt = prpi_pkg::S_SD_FIN;
      prpi_pkg::S_SD_FIN:   state_nxt = prpi_pkg::S_ST_DIV;
      prpi_pkg::S_ST_DIV:   if (div_cnt_r == '0) state_nxt = prpi_pkg::S_ST_FIN;
      prpi_pkg::S_ST_FIN:
        state_nxt = (edge_total_r == '0) ? prpi_pkg::S_UPD_RD : prpi_pkg::S_FLOW_RD;
      prpi_pkg::S_FLOW_RD:  state_nxt = prpi_pkg::S_FLOW_SRC;
      prpi_pkg::S_FLOW_SRC: begin
        if (!flow_skip) state_nxt = prpi_pkg::S_FLOW_ADD;
        else state_nxt = e_last ? prpi_pkg::S_UPD_RD : prpi_pkg::S_FLOW_RD;
      end
      prpi_pkg::S_FLOW_ADD: state_nxt = e_last ? prpi_pkg::S_UPD_RD : prpi_pkg::S_FLOW_RD;
      prpi_pkg::S_UPD_RD:   state_nxt = prpi_pkg::S_UPD_MUL;
      prpi_pkg::S_UPD_MUL:  state_nxt = prpi_pkg::S_UPD_WR;
      prpi_pkg::S_UPD_WR:   state_nxt = k_last ? prpi_pkg::S_ITER_END : prpi_pkg::S_UPD_RD;
      prpi_pkg::S_ITER_END: state_nxt = prpi_pkg::S_CHECK;
      default:              state_nxt = prpi_pkg::S_IDLE;
    endcase
  end

  // ---------------- outputs and memory control ----------------
  always_comb begin
    busy                 = state_r != prpi_pkg::S_IDLE;
    out_valid            = state_r == prpi_pkg::S_DONE;
    out_status           = status_r;
    out_rank_out         = rout_r;
    out_iterations_run   = iter_r;
    out_final_difference = last_r;

    rank_we = 1'b0;  rank_wa = k_addr;  rank_wd = upd_v;  rank_ra = k_addr;
    prev_we = 1'b0;
    cont_we = 1'b0;  cont_ra = VA'(fsrc);
    infl_we = 1'b0;  infl_wa = k_addr;  infl_wd = '0;     infl_ra = k_addr;
    deg_we  = 1'b0;  deg_wa  = k_addr;  deg_wd  = '0;     deg_ra  = k_addr;
    edge_we = 1'b0;  edge_wa = edge_total_r[EA-1:0];       edge_ra = e_r[EA-1:0];
    edge_wd = {src_r, dst_r};

    case (state_r)
      prpi_pkg::S_CLEAR: deg_we = 1'b1;
      prpi_pkg::S_CMD: begin
        deg_ra  = VA'(src_r);
        rank_ra = VA'(dst_r);
        rank_wa = VA'(dst_r);
        rank_wd = rin_r;
        rank_we = (cmd_r == prpi_pkg::CMD_WRITE_RANK) && !dst_bad;
      end
      prpi_pkg::S_EDGE_WR: begin
        deg_we  = 1'b1;
        deg_wa  = VA'(src_r);
        deg_wd  = deg_rd + DW'(1);
        edge_we = 1'b1;
      end
      prpi_pkg::S_NORM_WR: begin
        prev_we = 1'b1;
        cont_we = 1'b1;
        infl_we = 1'b1;
      end
      prpi_pkg::S_FLOW_SRC: infl_ra = VA'(fdst);
      prpi_pkg::S_FLOW_ADD: begin
        infl_we = 1'b1;
        infl_wa = VA'(fdst_r);
        infl_wd = flow_sat;
      end
      prpi_pkg::S_UPD_WR: rank_we = 1'b1;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prpi_pkg::S_CLEAR;
      vcount_r     <= prpi_pkg::VCOUNT_RST;
      damp_r       <= prpi_pkg::DAMP_RST;
      conv_r       <= prpi_pkg::CONV_RST;
      ilim_r       <= prpi_pkg::ILIM_RST;
      edge_total_r <= '0;
      iter_r       <= '0;
      last_r       <= '0;
      k_r          <= '0;
      status_r     <= prpi_pkg::ST_OK;
      rout_r       <= '0;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          prpi_pkg::CFG_VERTEX_COUNT: vcount_r <= cfg_data[prpi_pkg::VCNT_W-1:0];
          prpi_pkg::CFG_DAMPING:      damp_r   <= cfg_data[prpi_pkg::ALPHA_W-1:0];
          prpi_pkg::CFG_CONV_LIMIT:   conv_r   <= cfg_data[prpi_pkg::CONV_W-1:0];
          prpi_pkg::CFG_ITER_LIMIT:   ilim_r   <= cfg_data[prpi_pkg::ITER_W-1:0];
          default: ;
        endcase
      end

      // serial divider step
      if (in_div) begin
        div_rem_r <= div_ge ? div_diff[AW-1:0] : div_sh[AW-1:0];
        div_quo_r <= {div_quo_r[prpi_pkg::DIV_W-2:0], div_ge};
        div_num_r <= {div_num_r[prpi_pkg::DIV_W-2:0], 1'b0};
        div_cnt_r <= div_cnt_r - 1'b1;
      end

      case (state_r)
        prpi_pkg::S_CLEAR: k_r <= k_r + NW'(1);
        prpi_pkg::S_IDLE: begin
          if (start) begin
            cmd_r <= prpi_pkg::cmd_t'(in_cmd);
            src_r <= in_source_vertex;
            dst_r <= in_target_vertex;
            rin_r <= in_rank_in;
          end
        end
        prpi_pkg::S_CMD: begin
          status_r <= prpi_pkg::ST_OK;
          rout_r   <= '0;
          case (cmd_r)
            prpi_pkg::CMD_ADD_EDGE: begin
              if (src_bad || dst_bad) status_r <= prpi_pkg::ST_BAD_VERTEX;
              else if (store_full) status_r <= prpi_pkg::ST_FULL;
            end
            prpi_pkg::CMD_RUN: ;
            default: if (dst_bad) status_r <= prpi_pkg::ST_BAD_VERTEX;
          endcase
        end
        prpi_pkg::S_EDGE_WR: edge_total_r <= edge_total_r + ETW'(1);
        prpi_pkg::S_READ:    rout_r <= rank_rd;
        prpi_pkg::S_RUN_INIT: begin
          iter_r <= '0;
          last_r <= '0;
          diff_r <= prpi_pkg::RANK_ONE;
        end
        prpi_pkg::S_CHECK: begin
          k_r     <= '0;
          total_r <= '0;
          dang_r  <= '0;
        end
        prpi_pkg::S_SUM_ACC: begin
          total_r <= total_sat;
          if (deg_rd == '0) dang_r <= dang_sat;
          k_r <= k_last ? '0 : k_r + NW'(1);
        end
        prpi_pkg::S_NORM_LD: begin
          prev_r    <= rank_rd;
          deg_r     <= deg_rd;
          div_num_r <= {rank_rd, prpi_pkg::FRAC_W'(0)};
          div_den_r <= total_r;
          div_rem_r <= '0;
          div_quo_r <= '0;
          div_cnt_r <= prpi_pkg::DIV_CNT_W'(prpi_pkg::DIV_W - 1);
        end
        prpi_pkg::S_NORM_FIN: prev_r <= norm_q;
        prpi_pkg::S_DEG_LD: begin
          contrib_r <= '0;
          div_num_r <= prpi_pkg::DIV_W'(prev_r);
          div_den_r <= AW'(deg_r);
          div_rem_r <= '0;
          div_quo_r <= '0;
          div_cnt_r <= prpi_pkg::DIV_CNT_W'(prpi_pkg::DIV_W - 1);
        end
        prpi_pkg::S_DEG_FIN: contrib_r <= div_quo_r[prpi_pkg::RANK_W-1:0];
        prpi_pkg::S_NORM_WR: k_r <= k_last ? '0 : k_r + NW'(1);
        prpi_pkg::S_SHARE_MUL: begin
          phi_r <= phi_nxt;
          plo_r <= plo_nxt;
        end
        prpi_pkg::S_SD_LD: begin
          div_num_r <= prpi_pkg::DIV_W'(m_sum);
          div_den_r <= AW'(n);
          div_rem_r <= '0;
          div_quo_r <= '0;
          div_cnt_r <= prpi_pkg::DIV_CNT_W'(prpi_pkg::DIV_W - 1);
        end
        prpi_pkg::S_SD_FIN: begin
          sd_r      <= div_quo_r[AW-1:0];
          div_num_r <= prpi_pkg::DIV_W'({tele_w, 16'h0000});
          div_den_r <= AW'(n);
          div_rem_r <= '0;
          div_quo_r <= '0;
          div_cnt_r <= prpi_pkg::DIV_CNT_W'(prpi_pkg::DIV_W - 1);
        end
        prpi_pkg::S_ST_FIN: begin
          st_r   <= div_quo_r[prpi_pkg::RANK_W-1:0];
          diff_r <= '0;
          e_r    <= '0;
          k_r    <= '0;
        end
        prpi_pkg::S_FLOW_SRC: begin
          fdst_r <= fdst;
          if (flow_skip) e_r <= e_r + ETW'(1);
        end
        prpi_pkg::S_FLOW_ADD: e_r <= e_r + ETW'(1);
        prpi_pkg::S_UPD_MUL: begin
          phi_r <= phi_nxt;
          plo_r <= plo_nxt;
          old_r <= prev_rd;
        end
        prpi_pkg::S_UPD_WR: begin
          diff_r <= diff_sat;
          k_r    <= k_last ? '0 : k_r + NW'(1);
        end
        prpi_pkg::S_ITER_END: begin
          iter_r <= iter_r + 1'b1;
          last_r <= (diff_r > AW'(prpi_pkg::RANK_MAX)) ?
                    prpi_pkg::RANK_MAX : diff_r[prpi_pkg::RANK_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------- memories ----------------
  prpi_ram #(.WIDTH(prpi_pkg::RANK_W), .DEPTH(MAX_VERTICES)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(rank_wa), .wdata(rank_wd), .raddr(rank_ra), .rdata(rank_rd)
  );

  prpi_ram #(.WIDTH(prpi_pkg::RANK_W), .DEPTH(MAX_VERTICES)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(k_addr), .wdata(prev_r), .raddr(k_addr), .rdata(prev_rd)
  );

  prpi_ram #(.WIDTH(prpi_pkg::RANK_W), .DEPTH(MAX_VERTICES)) u_contrib_ram (
    .clk(clk), .we(cont_we), .waddr(k_addr), .wdata(contrib_r), .raddr(cont_ra),
    .rdata(cont_rd)
  );

  prpi_ram #(.WIDTH(prpi_pkg::ACC_W), .DEPTH(MAX_VERTICES)) u_inflow_ram (
    .clk(clk), .we(infl_we), .waddr(infl_wa), .wdata(infl_wd), .raddr(infl_ra), .rdata(infl_rd)
  );

  prpi_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_degree_ram (
    .clk(clk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd)
  );

  prpi_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd)
  );

endmodule

[bench/pagerank_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_checker
// Watches the request, result and configuration ports of the PageRank block.
// It keeps its own copy of the graph, the ranks and the registers, and works
// out the result of every accepted request. Each result is compared field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pagerank_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_cmd,
  input  logic [prpi_pkg::VID_W-1:0]     in_source_vertex,
  input  logic [prpi_pkg::VID_W-1:0]     in_target_vertex,
  input  logic [prpi_pkg::RANK_W-1:0]    in_rank_in,
  input  logic                           out_valid,
  input  logic [1:0]                     out_status,
  input  logic [prpi_pkg::RANK_W-1:0]    out_rank_out,
  input  logic [prpi_pkg::ITER_W-1:0]    out_iterations_run,
  input  logic [prpi_pkg::RANK_W-1:0]    out_final_difference,
  input  logic                           cfg_we,
  input  logic [prpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prpi_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             results_checked,
  output int                             runs_seen
);

  localparam int NV = 1024;
  localparam int NE = 8192;

  typedef struct packed {
    logic [1:0]                  status;
    logic [prpi_pkg::RANK_W-1:0] rank;
    logic [prpi_pkg::ITER_W-1:0] iters;
    logic [prpi_pkg::RANK_W-1:0] diff;
  } result_t;

  result_t result_q[$];

  // model state
  logic [63:0]                 rank_mem   [NV];
  logic [63:0]                 prev_mem   [NV];
  logic [63:0]                 inflow_mem [NV];
  int unsigned                 degree_mem [NV];
  int unsigned                 edge_src   [NE];
  int unsigned                 edge_dst   [NE];
  int unsigned                 edge_cnt;
  logic [prpi_pkg::ITER_W-1:0] iter_done;
  logic [63:0]                 last_delta;

  // register copies
  logic [prpi_pkg::VCNT_W-1:0]  n_reg;
  logic [prpi_pkg::ALPHA_W-1:0] alpha_reg;
  logic [prpi_pkg::CONV_W-1:0]  conv_reg;
  logic [prpi_pkg::ITER_W-1:0]  ilim_reg;

  assign pending = result_q.size();

  function automatic logic [63:0] acc_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > prpi_pkg::ACC_MAX) ? 64'(prpi_pkg::ACC_MAX) : s[63:0];
  endfunction

  // floor(x * d / 2^16)
  function automatic logic [63:0] alpha_scale(logic [63:0] x, logic [63:0] d);
    logic [127:0] p;
    p = 128'(x) * 128'(d);
    return 64'(p >> 16);
  endfunction

  // floor(a * 2^32 / b), clamped at the rank maximum
  function automatic logic [63:0] norm_ratio(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    q = (128'(a) << prpi_pkg::FRAC_W) / 128'(b);
    return (q > 128'(prpi_pkg::RANK_MAX)) ? 64'(prpi_pkg::RANK_MAX) : q[63:0];
  endfunction

  function automatic int unsigned live_vertices();
    if (n_reg == 0) return 1;
    if (n_reg > NV) return NV;
    return n_reg;
  endfunction

  // power iterations until converged or out of iterations
  task automatic power_iterate();
    int unsigned n;
    logic [63:0] diff, total, dangling, sh_dang, sh_tele, v, old;
    n = live_vertices();
    diff = 64'(prpi_pkg::RANK_ONE);
    iter_done = '0;
    last_delta = '0;
    while (diff > 64'(conv_reg) && iter_done < ilim_reg) begin
      total = '0;
      dangling = '0;
      for (int k = 0; k < n; k++) begin
        total = acc_add(total, rank_mem[k]);
        if (degree_mem[k] == 0) dangling = acc_add(dangling, rank_mem[k]);
      end
      for (int k = 0; k < n; k++) begin
        prev_mem[k] = (iter_done == 0 || total == 0) ? rank_mem[k]
                                                     : norm_ratio(rank_mem[k], total);
        inflow_mem[k] = '0;
      end
      sh_dang = alpha_scale(dangling, 64'(alpha_reg)) / n;
      sh_tele = ((64'd65536 - 64'(alpha_reg)) << (prpi_pkg::FRAC_W - 16)) / n;
      // stale edges (endpoint beyond n) are skipped
      for (int e = 0; e < edge_cnt; e++) begin
        if (edge_src[e] < n && edge_dst[e] < n && degree_mem[edge_src[e]] != 0)
          inflow_mem[edge_dst[e]] = acc_add(inflow_mem[edge_dst[e]],
                                            prev_mem[edge_src[e]] / degree_mem[edge_src[e]]);
      end
      diff = '0;
      for (int k = 0; k < n; k++) begin
        v = acc_add(acc_add(alpha_scale(inflow_mem[k], 64'(alpha_reg)), sh_dang), sh_tele);
        if (v > 64'(prpi_pkg::RANK_MAX)) v = 64'(prpi_pkg::RANK_MAX);
        old = prev_mem[k];
        rank_mem[k] = v;
        diff = acc_add(diff, (v >= old) ? v - old : old - v);
      end
      iter_done++;
      last_delta = (diff > 64'(prpi_pkg::RANK_MAX)) ? 64'(prpi_pkg::RANK_MAX) : diff;
    end
  endtask

  // apply one request to the model and return its result
  task automatic apply_request(output result_t r);
    int unsigned n, s, t;
    n = live_vertices();
    s = in_source_vertex;
    t = in_target_vertex;
    r = '0;
    r.status = prpi_pkg::ST_OK;
    case (prpi_pkg::cmd_t'(in_cmd))
      prpi_pkg::CMD_ADD_EDGE: begin
        if (s >= n || t >= n) r.status = prpi_pkg::ST_BAD_VERTEX;
        else if (edge_cnt >= NE) r.status = prpi_pkg::ST_FULL;
        else begin
          edge_src[edge_cnt] = s;
          edge_dst[edge_cnt] = t;
          edge_cnt++;
          degree_mem[s]++;
        end
      end
      prpi_pkg::CMD_WRITE_RANK: begin
        if (t >= n) r.status = prpi_pkg::ST_BAD_VERTEX;
        else rank_mem[t] = 64'(in_rank_in);
      end
      prpi_pkg::CMD_RUN: begin
        power_iterate();
        runs_seen++;
      end
      default: begin
        if (t >= n) r.status = prpi_pkg::ST_BAD_VERTEX;
        else r.rank = rank_mem[t][prpi_pkg::RANK_W-1:0];
      end
    endcase
    r.iters = iter_done;
    r.diff = last_delta[prpi_pkg::RANK_W-1:0];
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      n_reg = prpi_pkg::VCOUNT_RST;
      alpha_reg = prpi_pkg::DAMP_RST;
      conv_reg = prpi_pkg::CONV_RST;
      ilim_reg = prpi_pkg::ILIM_RST;
      for (int k = 0; k < NV; k++) degree_mem[k] = 0;
      edge_cnt = 0;
      iter_done = '0;
      last_delta = '0;
      result_q.delete();
    end else begin
      // compare a result with the oldest prediction
      if (out_valid) begin
        got = '{out_status, out_rank_out, out_iterations_run, out_final_difference};
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result status=%0d rank=%h iters=%0d diff=%h",
                     $realtime, got.status, got.rank, got.iters, got.diff);
        end else begin
          want = result_q.pop_front();
          results_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp status=%0d rank=%h iters=%0d diff=%h,",
                        " got status=%0d rank=%h iters=%0d diff=%h"}, $realtime,
                       want.status, want.rank, want.iters, want.diff,
                       got.status, got.rank, got.iters, got.diff);
          end
        end
      end
      // accepted request
      if (start && !busy) begin
        apply_request(want);
        result_q.push_back(want);
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          prpi_pkg::CFG_VERTEX_COUNT: n_reg = cfg_data[prpi_pkg::VCNT_W-1:0];
          prpi_pkg::CFG_DAMPING:      alpha_reg = cfg_data[prpi_pkg::ALPHA_W-1:0];
          prpi_pkg::CFG_CONV_LIMIT:   conv_reg = cfg_data[prpi_pkg::CONV_W-1:0];
          prpi_pkg::CFG_ITER_LIMIT:   ilim_reg = cfg_data[prpi_pkg::ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    fail_count = 0;
    results_checked = 0;
    runs_seen = 0;
  end

endmodule

[bench/tb_pagerank_power_iteration.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pagerank_power_iteration
// Drives requests and register writes into the PageRank block: a directed
// opening over the corner cases, random traffic in several idle phases, and a
// check of the vertex-count clamp at the top of the range. The checker does
// the compare.
// ----------------------------------------------------------------------------
module tb_pagerank_power_iteration;

  localparam int NV        = 1024;
  localparam int NE        = 8192;
  localparam int RAND_REQS = 190;   // per idle phase
  localparam int EDGE_CAP  = 400;   // random edges, keeps runs short
  localparam longint CYCLE_LIMIT = 6000000;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [1:0]                     in_cmd;
  logic [prpi_pkg::VID_W-1:0]     in_source_vertex;
  logic [prpi_pkg::VID_W-1:0]     in_target_vertex;
  logic [prpi_pkg::RANK_W-1:0]    in_rank_in;
  logic                           out_valid;
  logic [1:0]                     out_status;
  logic [prpi_pkg::RANK_W-1:0]    out_rank_out;
  logic [prpi_pkg::ITER_W-1:0]    out_iterations_run;
  logic [prpi_pkg::RANK_W-1:0]    out_final_difference;
  logic                           cfg_we;
  logic [prpi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [prpi_pkg::CFG_W-1:0]     cfg_data;

  int fail_count, pending, results_checked, runs_seen;

  // stimulus bookkeeping
  int     n_live;
  int     edges_loaded;
  int     idle_pct;
  bit     rank_set [NV];
  longint cycles;

  pagerank_power_iteration dut (.*);

  pagerank_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [prpi_pkg::RANK_W-1:0] rand_rank();
    case ($urandom_range(0, 3))
      0:       return prpi_pkg::RANK_W'($urandom_range(0, 1)) << 32 |
                      prpi_pkg::RANK_W'($urandom());
      1:       return prpi_pkg::RANK_W'($urandom_range(0, 1)) << 32;
      default: return prpi_pkg::RANK_W'($urandom() >> $urandom_range(0, 12));
    endcase
  endfunction

  // one request, held until the block takes it
  task automatic send_req(prpi_pkg::cmd_t c, int s, int t,
                          logic [prpi_pkg::RANK_W-1:0] r);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_source_vertex <= prpi_pkg::VID_W'(s);
    in_target_vertex <= prpi_pkg::VID_W'(t);
    in_rank_in <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c == prpi_pkg::CMD_WRITE_RANK && t < n_live) rank_set[t] = 1'b1;
    if (c == prpi_pkg::CMD_ADD_EDGE && s < n_live && t < n_live && edges_loaded < NE)
      edges_loaded++;
  endtask

  // wait until every result is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [prpi_pkg::CFG_IDX_W-1:0] idx,
                           logic [prpi_pkg::CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == prpi_pkg::CFG_VERTEX_COUNT)
      n_live = (val[prpi_pkg::VCNT_W-1:0] == 0) ? 1 :
               (val[prpi_pkg::VCNT_W-1:0] > NV) ? NV : int'(val[prpi_pkg::VCNT_W-1:0]);
  endtask

  // every live vertex needs a rank before a run
  task automatic run_req();
    for (int k = 0; k < n_live; k++)
      if (!rank_set[k]) send_req(prpi_pkg::CMD_WRITE_RANK, 0, k, rand_rank());
    send_req(prpi_pkg::CMD_RUN, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
             rand_rank());
  endtask

  task automatic random_req();
    int s, t, pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      s = $urandom_range(0, NV - 1);
      t = $urandom_range(0, NV - 1);
    end else begin
      s = $urandom_range(0, n_live - 1);
      t = $urandom_range(0, n_live - 1);
    end
    if (pick < 35) begin
      if (s < n_live && t < n_live && edges_loaded >= EDGE_CAP)
        send_req(prpi_pkg::CMD_WRITE_RANK, s, t, rand_rank());
      else
        send_req(prpi_pkg::CMD_ADD_EDGE, s, t, rand_rank());
    end else if (pick < 67) begin
      send_req(prpi_pkg::CMD_WRITE_RANK, s, t, rand_rank());
    end else if (pick < 95) begin
      if (t < n_live && !rank_set[t]) send_req(prpi_pkg::CMD_WRITE_RANK, s, t, rand_rank());
      send_req(prpi_pkg::CMD_READ_RANK, s, t, rand_rank());
    end else begin
      run_req();
    end
  endtask

  task automatic random_settings();
    case ($urandom_range(0, 7))
      0:       cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 0);
      default: cfg_write(prpi_pkg::CFG_VERTEX_COUNT, $urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 3))
      0:       cfg_write(prpi_pkg::CFG_DAMPING, 0);
      1:       cfg_write(prpi_pkg::CFG_DAMPING, 16'hFFFF);
      default: cfg_write(prpi_pkg::CFG_DAMPING, $urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 2))
      0:       cfg_write(prpi_pkg::CFG_CONV_LIMIT, $urandom());
      default: cfg_write(prpi_pkg::CFG_CONV_LIMIT, $urandom() >> $urandom_range(8, 31));
    endcase
    cfg_write(prpi_pkg::CFG_ITER_LIMIT, $urandom_range(0, 6));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = prpi_pkg::CMD_ADD_EDGE;
    in_source_vertex = '0;
    in_target_vertex = '0;
    in_rank_in = '0;
    cfg_we = 1'b0;
    cfg_index = prpi_pkg::CFG_VERTEX_COUNT;
    cfg_data = '0;
    n_live = NV;
    edges_loaded = 0;
    idle_pct = 0;
    foreach (rank_set[k]) rank_set[k] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad vertices, rank extremes, all-dangling run
    cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 4);
    cfg_write(prpi_pkg::CFG_ITER_LIMIT, 3);
    send_req(prpi_pkg::CMD_READ_RANK, 0, 5, '0);
    send_req(prpi_pkg::CMD_WRITE_RANK, 0, 4, prpi_pkg::RANK_MAX);
    send_req(prpi_pkg::CMD_ADD_EDGE, 4, 0, '0);
    send_req(prpi_pkg::CMD_ADD_EDGE, 0, NV - 1, '0);
    send_req(prpi_pkg::CMD_WRITE_RANK, 0, 0, '0);
    send_req(prpi_pkg::CMD_WRITE_RANK, 0, 1, prpi_pkg::RANK_MAX);
    send_req(prpi_pkg::CMD_WRITE_RANK, 0, 2, prpi_pkg::RANK_W'(prpi_pkg::RANK_ONE));
    send_req(prpi_pkg::CMD_WRITE_RANK, 0, 3, 33'h0AAAAAAAA);
    send_req(prpi_pkg::CMD_READ_RANK, 0, 1, '0);
    send_req(prpi_pkg::CMD_RUN, 0, 0, '0);
    send_req(prpi_pkg::CMD_ADD_EDGE, 0, 1, '0);
    send_req(prpi_pkg::CMD_ADD_EDGE, 1, 2, '0);
    send_req(prpi_pkg::CMD_ADD_EDGE, 2, 0, '0);
    send_req(prpi_pkg::CMD_ADD_EDGE, 3, 3, '0);
    // single vertex, huge iteration limit, loose threshold
    cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 1);
    cfg_write(prpi_pkg::CFG_DAMPING, 16'hFFFF);
    cfg_write(prpi_pkg::CFG_CONV_LIMIT, 32'hFFFF_FFFF);
    cfg_write(prpi_pkg::CFG_ITER_LIMIT, 16'hFFFF);
    send_req(prpi_pkg::CMD_WRITE_RANK, 0, 0, prpi_pkg::RANK_W'(prpi_pkg::RANK_ONE));
    send_req(prpi_pkg::CMD_RUN, 0, 0, '0);
    // no iterations at all
    cfg_write(prpi_pkg::CFG_ITER_LIMIT, 0);
    send_req(prpi_pkg::CMD_RUN, 0, 0, '0);
    // zero vertex count acts as one
    cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 0);
    cfg_write(prpi_pkg::CFG_DAMPING, 0);
    cfg_write(prpi_pkg::CFG_CONV_LIMIT, 0);
    cfg_write(prpi_pkg::CFG_ITER_LIMIT, 4);
    send_req(prpi_pkg::CMD_RUN, 0, 0, '0);
    send_req(prpi_pkg::CMD_READ_RANK, 0, 0, '0);
    // stale edges after lowering the vertex count
    cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 8);
    cfg_write(prpi_pkg::CFG_DAMPING, 55705);
    for (int k = 4; k < 8; k++) send_req(prpi_pkg::CMD_WRITE_RANK, 0, k, rand_rank());
    send_req(prpi_pkg::CMD_ADD_EDGE, 5, 1, '0);
    send_req(prpi_pkg::CMD_ADD_EDGE, 2, 6, '0);
    cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 4);
    run_req();

    // random traffic under each idle profile
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 48 : (ph == 3) ? 14 : 0;
      random_settings();
      for (int i = 0; i < RAND_REQS; i++) begin
        random_req();
        if (i % 70 == 69) random_settings();
      end
    end

    // vertex count above the maximum acts as the maximum
    idle_pct = 14;
    cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 11'h7FF);
    send_req(prpi_pkg::CMD_WRITE_RANK, 0, NV - 1, rand_rank());
    send_req(prpi_pkg::CMD_ADD_EDGE, NV - 1, NV - 1, '0);
    send_req(prpi_pkg::CMD_READ_RANK, NV - 1, NV - 1, '0);

    // bad vertex after lowering the count again, then a small run
    idle_pct = 0;
    cfg_write(prpi_pkg::CFG_VERTEX_COUNT, 4);
    send_req(prpi_pkg::CMD_ADD_EDGE, 9, 1, '0);
    run_req();

    drain();
    repeat (20) @(posedge clk);
    $display("checked %0d results, %0d of them runs, %0d edges loaded",
             results_checked, runs_seen, edges_loaded);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
